[hw/rtl/fafp_pkg.sv]
// ----------------------------------------------------------------------------
// fafp_pkg: shared definitions for the first-fit archive packer
// Status codes, register indexes, size-estimate constants and the request
// struct passed from the sequencer to the divider.
// ----------------------------------------------------------------------------
package fafp_pkg;

	// Default number of bins held in the fill memory.
	localparam int NUM_BINS_DEF = 32;

	// Field widths fixed by the interface.
	localparam int NAME_W  = 10;
	localparam int BYTES_W = 32;
	localparam int EST_W   = 33;
	localparam int FILL_W  = 32;
	localparam int BIN_W   = 5;
	localparam int BIU_W   = 6;

	// Width of the compression divisors.
	localparam int REM_W = 6;

	// Size-estimate constants.
	localparam logic [EST_W-1:0] FILE_BASE = 33'd325;
	localparam logic [EST_W-1:0] DIR_BASE  = 33'd80;
	localparam logic [REM_W-1:0] DIV_SRC   = 6'd25;
	localparam logic [REM_W-1:0] DIV_BIN   = 6'd60;

	// Reciprocals of the divisors: the quotient of any 32-bit byte count is
	// the product with the reciprocal shifted right by the matching amount.
	localparam logic [BYTES_W-1:0] RECIP_SRC = 32'h51EB_851F;
	localparam int                 SHIFT_SRC = 35;
	localparam logic [BYTES_W-1:0] RECIP_BIN = 32'h8888_8889;
	localparam int                 SHIFT_BIN = 37;

	// Starting fill of each bin.
	localparam logic [FILL_W-1:0] FILL_BIN0  = 32'd3000;
	localparam logic [FILL_W-1:0] FILL_OTHER = 32'd1000;

	// Register reset values.
	localparam logic [31:0]      SIZE_LIMIT_RST = 32'd55000;
	localparam logic [BIU_W-1:0] BINS_RST       = 6'd20;

	// Configuration register indexes.
	localparam logic REG_SIZE_LIMIT  = 1'b0;
	localparam logic REG_BINS_IN_USE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_PLACED  = 2'd0;
	localparam logic [1:0] ST_TOO_BIG = 2'd1;
	localparam logic [1:0] ST_NO_ROOM = 2'd2;
	localparam logic [1:0] ST_CLEARED = 2'd3;

	// Divider start request.
	typedef struct packed {
		logic start;
		logic source_text;
	} div_req_t;

endpackage

[hw/rtl/fafp_div.sv]
// ----------------------------------------------------------------------------
// fafp_div: constant divider for the compression allowance
// Divides a 32-bit byte count by 25 or 60 through a reciprocal multiply:
// operands load on start, the product registers in the next cycle, and done
// pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module fafp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fafp_pkg::div_req_t                req,
	input  logic [fafp_pkg::BYTES_W-1:0]      dividend,
	output logic [fafp_pkg::BYTES_W-1:0]      quotient,
	output logic                              done
);

	localparam int PROD_W = 2 * fafp_pkg::BYTES_W;

	logic                              mul_q;
	logic                              done_q;
	logic                              src_q;
	logic [fafp_pkg::BYTES_W-1:0]      dvd_q;
	logic [fafp_pkg::BYTES_W-1:0]      recip_q;
	logic [PROD_W-1:0]                 prod_q;

	// Control: the multiply follows the operand load, done follows the multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= req.start;
			done_q <= mul_q;
		end
	end

	// Datapath: operand registers and the registered product.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q   <= dividend;
			src_q   <= req.source_text;
			recip_q <= req.source_text ? fafp_pkg::RECIP_SRC : fafp_pkg::RECIP_BIN;
		end
		if (mul_q) begin
			prod_q <= PROD_W'(dvd_q) * PROD_W'(recip_q);
		end
	end

	// The high part of the product is the quotient.
	assign quotient = src_q ? fafp_pkg::BYTES_W'(prod_q >> fafp_pkg::SHIFT_SRC)
		: fafp_pkg::BYTES_W'(prod_q >> fafp_pkg::SHIFT_BIN);
	assign done     = done_q;

endmodule

[hw/rtl/first_fit_archive_packer_core.sv]
// ----------------------------------------------------------------------------
// first_fit_archive_packer_core: first-fit placement of archive entries
// Estimates the archived size of each entry and places it into the first
// bin with room, keeping the fill of every bin in a small memory.
// ----------------------------------------------------------------------------
// Usage:
// An entry request is taken on the in channel (in_valid/in_ready) and one
// result request leaves on the out channel (out_valid/out_ready) per entry.
// The block works on one request at a time; in_ready is high only while it
// is waiting for work. For a file, out_valid rises without a walk when it is
// too big; otherwise the walk stops at the first bin with room, or after all
// searched bins when none has room. The estimate waits on the reciprocal
// multiply of the divider, then the walk compares one bin per cycle behind a
// registered memory read. A directory skips the multiply; a clear goes
// straight to its result. in_ready returns the cycle after a result is
// registered, so a request is taken only after the last result. The
// configuration port (cfg_we, cfg_index, cfg_data) sets the size limit and
// the number of bins searched; write it only while idle. Reset sets them to
// 55000 and 20 and marks every bin as holding its starting overhead, with no
// clearing pass. A result waits in the output register while out_ready is
// low; the next finished result is held in the block, with in_ready low,
// until it frees.
// ----------------------------------------------------------------------------
module first_fit_archive_packer_core #(
	parameter int NUM_BINS = fafp_pkg::NUM_BINS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Entry requests.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic                              is_directory,
	input  logic [fafp_pkg::NAME_W-1:0]       name_length,
	input  logic [fafp_pkg::BYTES_W-1:0]      file_bytes,
	input  logic                              source_text,
	// Result requests.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fafp_pkg::BIN_W-1:0]        bin_index,
	output logic [1:0]                        status,
	output logic [fafp_pkg::EST_W-1:0]        estimated_size,
	// Configuration writes.
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CNT_W = $clog2(NUM_BINS + 1);
	localparam int CMP_W = 9;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_SUM   = 6'b000100,
		S_CHECK = 6'b001000,
		S_WALK  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                            state_q;
	logic [31:0]                       size_limit_q;
	logic [fafp_pkg::BIU_W-1:0]        bins_in_use_q;

	logic                              dir_q;
	logic [fafp_pkg::NAME_W-1:0]       name_q;
	logic [fafp_pkg::BYTES_W-1:0]      bytes_q;
	logic [fafp_pkg::EST_W-1:0]        est_q;
	logic [1:0]                        res_status_q;
	logic [IDX_W-1:0]                  res_idx_q;

	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  issue_q;
	logic                              vld_s1;
	logic [IDX_W-1:0]                  idx_s1;
	logic [fafp_pkg::FILL_W-1:0]       rd_data_s1;
	logic [NUM_BINS-1:0]               written_q;
	logic [fafp_pkg::FILL_W-1:0]       fill_mem [NUM_BINS];

	logic                              out_valid_q;
	logic [fafp_pkg::BIN_W-1:0]        out_bin_q;
	logic [1:0]                        out_status_q;
	logic [fafp_pkg::EST_W-1:0]        out_est_q;

	fafp_pkg::div_req_t                div_req;
	logic [fafp_pkg::BYTES_W-1:0]      quotient;
	logic                              div_done;

	logic                              in_fire;
	logic                              out_load;
	logic [fafp_pkg::FILL_W-1:0]       cur_fill;
	logic [fafp_pkg::FILL_W+1:0]       fill_sum;
	logic                              hit;
	logic                              exhausted;
	logic                              clear_all;
	logic [CMP_W-1:0]                  biu_ext;
	logic [CMP_W-1:0]                  count_clamp;
	logic [fafp_pkg::EST_W-1:0]        est_next;
	logic [IDX_W+fafp_pkg::BIN_W-1:0]  bin_wide;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q  <= fafp_pkg::SIZE_LIMIT_RST;
			bins_in_use_q <= fafp_pkg::BINS_RST;
		end else if (cfg_we) begin
			if (cfg_index == fafp_pkg::REG_SIZE_LIMIT) begin
				size_limit_q <= cfg_data;
			end else begin
				bins_in_use_q <= cfg_data[fafp_pkg::BIU_W-1:0];
			end
		end
	end

	// Divider for the compression allowance of a file.
	assign div_req.start       = in_fire && !kind && !is_directory;
	assign div_req.source_text = source_text;

	fafp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (file_bytes),
		.quotient (quotient),
		.done     (div_done)
	);

	// Size estimate for a file or a directory.
	always_comb begin
		if (dir_q) begin
			est_next = fafp_pkg::EST_W'({name_q, 2'b00}) + fafp_pkg::DIR_BASE;
		end else begin
			est_next = fafp_pkg::EST_W'({name_q, 3'b000}) + fafp_pkg::FILE_BASE
				+ fafp_pkg::EST_W'(bytes_q) + fafp_pkg::EST_W'(quotient);
		end
	end

	// Searched bin count, limited to the bins that exist.
	assign biu_ext     = CMP_W'(bins_in_use_q);
	assign count_clamp = (biu_ext > CMP_W'(NUM_BINS)) ? CMP_W'(NUM_BINS) : biu_ext;

	// Compare stage of the walk: a bin never written holds its starting overhead.
	always_comb begin
		if (written_q[idx_s1]) begin
			cur_fill = rd_data_s1;
		end else if (idx_s1 == '0) begin
			cur_fill = fafp_pkg::FILL_BIN0;
		end else begin
			cur_fill = fafp_pkg::FILL_OTHER;
		end
	end

	assign fill_sum  = {2'b00, cur_fill} + {1'b0, est_q};
	assign hit       = (state_q == S_WALK) && vld_s1 && (fill_sum <= {2'b00, size_limit_q});
	assign exhausted = (state_q == S_WALK) && !vld_s1 && (issue_q >= count_q);
	assign clear_all = in_fire && kind;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1  <= 1'b0;
			issue_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (kind) begin
							state_q <= S_DONE;
						end else if (is_directory) begin
							state_q <= S_SUM;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					issue_q <= '0;
					vld_s1  <= 1'b0;
					count_q <= count_clamp[CNT_W-1:0];
					if (est_q > fafp_pkg::EST_W'(size_limit_q)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (hit || exhausted) begin
						vld_s1  <= 1'b0;
						state_q <= S_DONE;
					end else if (issue_q < count_q) begin
						vld_s1  <= 1'b1;
						issue_q <= issue_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields, estimate and pending result.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dir_q   <= is_directory;
			name_q  <= name_length;
			bytes_q <= file_bytes;
			if (kind) begin
				est_q        <= '0;
				res_status_q <= fafp_pkg::ST_CLEARED;
				res_idx_q    <= '0;
			end
		end
		if (state_q == S_SUM) begin
			est_q <= est_next;
		end
		if (state_q == S_CHECK) begin
			res_status_q <= fafp_pkg::ST_TOO_BIG;
			res_idx_q    <= '0;
		end
		if (hit) begin
			res_status_q <= fafp_pkg::ST_PLACED;
			res_idx_q    <= idx_s1;
		end else if (exhausted) begin
			res_status_q <= fafp_pkg::ST_NO_ROOM;
		end
		if ((state_q == S_WALK) && (issue_q < count_q)) begin
			idx_s1 <= issue_q[IDX_W-1:0];
		end
	end

	// Fill memory: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		if (hit) begin
			fill_mem[idx_s1] <= fill_sum[fafp_pkg::FILL_W-1:0];
		end
		rd_data_s1 <= fill_mem[issue_q[IDX_W-1:0]];
	end

	// Written flags: a cleared bin reads as its starting overhead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (clear_all) begin
			written_q <= '0;
		end else if (hit) begin
			written_q[idx_s1] <= 1'b1;
		end
	end

	// Output register.
	assign bin_wide = {{fafp_pkg::BIN_W{1'b0}}, res_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bin_q    <= bin_wide[fafp_pkg::BIN_W-1:0];
			out_status_q <= res_status_q;
			out_est_q    <= est_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign bin_index      = out_bin_q;
	assign status         = out_status_q;
	assign estimated_size = out_est_q;

	// A placed entry never exceeds the size limit.
	a_placed_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == fafp_pkg::ST_PLACED)
		|-> (out_est_q <= fafp_pkg::EST_W'(size_limit_q)))
		else $error("placed entry larger than the size limit");

	// A too-big result carries an estimate above the limit.
	a_too_big: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == fafp_pkg::ST_TOO_BIG)
		|-> (out_est_q > fafp_pkg::EST_W'(size_limit_q)))
		else $error("too-big result within the size limit");

	// A clear result reports bin zero and no size.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == fafp_pkg::ST_CLEARED)
		|-> (out_est_q == '0) && (out_bin_q == '0))
		else $error("clear result with nonzero fields");

	// The walk only compares bins inside the searched range.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CNT_W'(idx_s1) < count_q))
		else $error("walk compared a bin outside the searched range");

endmodule
